FILE: rtl/mer_pkg.sv
package mer_pkg;

  // radius fields are fixed at five bits, so the arithmetic widths below
  // are sized for radii up to 31
  localparam int RADIUS_W = 5;
  // x may step past the radius only within the 63-step walk
  localparam int XW       = 6;
  localparam int SQ_W     = 10;   // radius squared
  localparam int PROD_W   = 16;   // radius squared times x or y
  localparam int DEC_W    = 28;   // scaled decision value, signed
  localparam int CNT_W    = 6;    // points emitted per command

  localparam int QD       = 2;    // command queue depth
  localparam int QP_W     = 1;

  // per-command setup passed from the front end to the walker
  typedef struct packed {
    logic [SQ_W-1:0]     a2;
    logic [SQ_W-1:0]     b2;
    logic [PROD_W-1:0]   ay0;
    logic [RADIUS_W-1:0] b;
  } mer_geom_t;

endpackage

FILE: rtl/mer_if.sv
interface mer_cmd_if #(
  parameter int COORD_WIDTH = 12
);
  logic                             valid;
  logic                             ready;
  logic signed [COORD_WIDTH-1:0]    center_x;
  logic signed [COORD_WIDTH-1:0]    center_y;
  logic [mer_pkg::RADIUS_W-1:0]     radius_a;
  logic [mer_pkg::RADIUS_W-1:0]     radius_b;

  modport source (output valid, center_x, center_y, radius_a, radius_b, input ready);
  modport sink (input valid, center_x, center_y, radius_a, radius_b, output ready);
endinterface

interface mer_pt_if #(
  parameter int COORD_WIDTH = 12
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH:0]   q1_x;
  logic signed [COORD_WIDTH:0]   q1_y;
  logic signed [COORD_WIDTH:0]   q2_x;
  logic signed [COORD_WIDTH:0]   q2_y;
  logic signed [COORD_WIDTH:0]   q3_x;
  logic signed [COORD_WIDTH:0]   q3_y;
  logic signed [COORD_WIDTH:0]   q4_x;
  logic signed [COORD_WIDTH:0]   q4_y;
  logic                          last_step;

  modport source (output valid, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y, q4_x, q4_y,
                  last_step, input ready);
  modport sink (input valid, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y, q4_x, q4_y,
                last_step, output ready);
endinterface

FILE: rtl/midpoint_ellipse_rasterizer_core.sv
// A command passes the two front-end stages and the queue; the walker loads it
// while idle, and its first point set is then registered at the output.
// Throughput: one point set per cycle while a command walks and the output is not
// stalled, plus a load state per command and a region change state when the walk
// reaches region 2; the single stepping walker takes no new command until done.
// Reset: synchronous, active high; clears all valid flags and the walker state.
module midpoint_ellipse_rasterizer_core #(
  parameter int MAX_RADIUS  = 31,
  parameter int COORD_WIDTH = 12
) (
  input  logic      clk,
  input  logic      rst,
  mer_cmd_if.sink   cmd,
  mer_pt_if.source  pt
);

  localparam int GEOM_W  = $bits(mer_pkg::mer_geom_t);
  localparam int ENTRY_W = 2 * COORD_WIDTH + GEOM_W;

  // front end -> queue
  logic                       f_valid;
  logic                       f_ready;
  logic [2*COORD_WIDTH-1:0]   f_ctr;
  mer_pkg::mer_geom_t         f_geom;

  // queue -> walker
  logic                       q_valid;
  logic                       q_ready;
  logic [ENTRY_W-1:0]         q_data;
  logic [2*COORD_WIDTH-1:0]   w_ctr;
  mer_pkg::mer_geom_t         w_geom;

  // Front end: clamp radii, square them, form a^2 b. Two pipeline stages,
  // so a new command can be taken every cycle until the queue backs up.
  mer_front #(
    .MAX_RADIUS  (MAX_RADIUS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_ctr   (f_ctr),
    .out_geom  (f_geom)
  );

  // Short queue: lets the front end set up the next command while the
  // walker is still emitting points of the current one.
  mer_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_ctr, f_geom}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign w_ctr  = q_data[ENTRY_W-1 -: 2*COORD_WIDTH];
  assign w_geom = mer_pkg::mer_geom_t'(q_data[GEOM_W-1:0]);

  // Walker: incremental midpoint stepping with adds only. The b^2 x and
  // a^2 y terms are carried as running sums, so the region change needs no
  // multiplier. Results leave through a registered output stage.
  mer_walk #(
    .MAX_RADIUS  (MAX_RADIUS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_ctr   (w_ctr),
    .in_geom  (w_geom),
    .pt       (pt)
  );

endmodule

FILE: rtl/mer_front.sv
module mer_front #(
  parameter int MAX_RADIUS  = 31,
  parameter int COORD_WIDTH = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  mer_cmd_if.sink                    cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2*COORD_WIDTH-1:0]   out_ctr,
  output mer_pkg::mer_geom_t         out_geom
);

  localparam logic [mer_pkg::RADIUS_W-1:0] RMAX = mer_pkg::RADIUS_W'(MAX_RADIUS);

  logic                               s1_valid;
  logic [2*COORD_WIDTH-1:0]           s1_ctr;
  logic [mer_pkg::RADIUS_W-1:0]       s1_b;
  logic [mer_pkg::SQ_W-1:0]           s1_a2;
  logic [mer_pkg::SQ_W-1:0]           s1_b2;
  logic                               s2_valid;
  logic                               s2_load;
  logic [mer_pkg::RADIUS_W-1:0]       ra_sat;
  logic [mer_pkg::RADIUS_W-1:0]       rb_sat;

  // clamp radii to the supported maximum
  assign ra_sat = (cmd.radius_a > RMAX) ? RMAX : cmd.radius_a;
  assign rb_sat = (cmd.radius_b > RMAX) ? RMAX : cmd.radius_b;

  assign s2_load   = s1_valid && (!s2_valid || out_ready);
  assign cmd.ready = !s1_valid || s2_load;
  assign out_valid = s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (cmd.ready) begin
        s1_valid <= cmd.valid;
      end
      if (!s2_valid || out_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // stage 1: square the radii; stage 2: a^2 * b for the starting y term
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_ctr <= {cmd.center_x, cmd.center_y};
      s1_b   <= rb_sat;
      s1_a2  <= mer_pkg::SQ_W'(ra_sat) * mer_pkg::SQ_W'(ra_sat);
      s1_b2  <= mer_pkg::SQ_W'(rb_sat) * mer_pkg::SQ_W'(rb_sat);
    end
    if (s2_load) begin
      out_ctr       <= s1_ctr;
      out_geom.a2   <= s1_a2;
      out_geom.b2   <= s1_b2;
      out_geom.b    <= s1_b;
      out_geom.ay0  <= mer_pkg::PROD_W'(s1_a2) * mer_pkg::PROD_W'(s1_b);
    end
  end

endmodule

FILE: rtl/mer_queue.sv
module mer_queue #(
  parameter int W = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [W-1:0]  push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [W-1:0]  pop_data
);

  localparam logic [mer_pkg::QP_W-1:0] LAST_PTR = mer_pkg::QP_W'(mer_pkg::QD - 1);

  logic [W-1:0]               mem [mer_pkg::QD];
  logic [mer_pkg::QP_W-1:0]   wr_ptr;
  logic [mer_pkg::QP_W-1:0]   rd_ptr;
  logic [mer_pkg::QP_W:0]     count;
  logic                       push;
  logic                       pop;

  assign push_ready = (count != (mer_pkg::QP_W + 1)'(mer_pkg::QD));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/mer_walk.sv
module mer_walk #(
  parameter int MAX_RADIUS  = 31,
  parameter int COORD_WIDTH = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2*COORD_WIDTH-1:0]   in_ctr,
  input  mer_pkg::mer_geom_t         in_geom,
  mer_pt_if.source                   pt
);

  localparam int CW        = COORD_WIDTH;
  localparam int OW        = COORD_WIDTH + 1;
  localparam int DW        = mer_pkg::DEC_W;
  localparam int MAX_STEPS = 2 * MAX_RADIUS + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_R1   = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_R2   = 4'b1000
  } walk_state_t;

  walk_state_t                    state;
  logic signed [CW-1:0]           cx;
  logic signed [CW-1:0]           cy;
  logic [mer_pkg::SQ_W-1:0]       a2;
  logic [mer_pkg::SQ_W-1:0]       b2;
  logic [mer_pkg::XW-1:0]         x;
  logic [mer_pkg::RADIUS_W-1:0]   y;
  logic [mer_pkg::PROD_W-1:0]     bx;
  logic [mer_pkg::PROD_W-1:0]     ay;
  logic signed [DW-1:0]           d;
  logic [mer_pkg::CNT_W-1:0]      cnt;

  logic signed [DW-1:0]           a2e, b2e, bxe, aye;
  logic signed [DW-1:0]           inc_x1, inc_y1, step_y2, d_init, d2_init;
  logic                           test;
  logic                           d_neg;
  logic [mer_pkg::CNT_W-1:0]      cnt_inc;
  logic                           at_limit;
  logic                           last_r1;
  logic                           last_r2;
  logic                           out_free;
  logic                           emit;
  logic                           last;
  logic [mer_pkg::XW-1:0]         px;
  logic [mer_pkg::RADIUS_W-1:0]   py;
  logic signed [OW-1:0]           cxe, cye, pxe, pye;

  assign a2e = DW'(a2);
  assign b2e = DW'(b2);
  assign bxe = DW'(bx);
  assign aye = DW'(ay);
  assign d_neg = d[DW-1];

  // region 1 continues while a^2 (2y - 1) > 2 b^2 (x + 1)
  assign test    = ((aye <<< 1) - a2e) > ((bxe <<< 1) + (b2e <<< 1));
  assign inc_x1  = (bxe <<< 3) + (b2e <<< 3) + (b2e <<< 2);
  assign inc_y1  = (a2e <<< 3) - (aye <<< 3);
  assign step_y2 = (a2e <<< 3) + (a2e <<< 2) - (aye <<< 3);
  // region 2 decision from region 1 decision at the same point
  assign d2_init = d - (bxe <<< 2) - (b2e <<< 1) - b2e + (a2e <<< 1) + a2e - (aye <<< 2);
  assign d_init  = (DW'(in_geom.b2) <<< 2) - (DW'(in_geom.ay0) <<< 2) + DW'(in_geom.a2);

  assign cnt_inc  = cnt + 1'b1;
  assign at_limit = (cnt_inc == mer_pkg::CNT_W'(MAX_STEPS));
  assign last_r1  = at_limit || (!test && (y == '0));
  assign last_r2  = at_limit || (py == '0);

  // region 1 shows the held point; region 2 shows the point after its step
  assign px = ((state == ST_R2) && d_neg) ? x + 1'b1 : x;
  assign py = (state == ST_R2) ? y - 1'b1 : y;

  assign out_free = !pt.valid || pt.ready;
  assign emit     = out_free && ((state == ST_R1) || (state == ST_R2));
  assign last     = (state == ST_R1) ? last_r1 : last_r2;
  assign in_ready = (state == ST_IDLE);

  assign cxe = {cx[CW-1], cx};
  assign cye = {cy[CW-1], cy};
  assign pxe = OW'(px);
  assign pye = OW'(py);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_R1;
          end
        end
        ST_R1: begin
          if (out_free) begin
            if (last_r1) begin
              state <= ST_IDLE;
            end else if (!test) begin
              state <= ST_FIX;
            end
          end
        end
        ST_FIX: state <= ST_R2;
        ST_R2: begin
          if (out_free && last_r2) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cx  <= in_ctr[2*CW-1:CW];
          cy  <= in_ctr[CW-1:0];
          a2  <= in_geom.a2;
          b2  <= in_geom.b2;
          ay  <= in_geom.ay0;
          bx  <= '0;
          x   <= '0;
          y   <= in_geom.b;
          d   <= d_init;
          cnt <= '0;
        end
      end
      ST_R1: begin
        if (out_free) begin
          cnt <= cnt_inc;
          if (!last_r1 && test) begin
            x  <= x + 1'b1;
            bx <= bx + mer_pkg::PROD_W'(b2);
            if (d_neg) begin
              d <= d + inc_x1;
            end else begin
              d  <= d + inc_x1 + inc_y1;
              y  <= y - 1'b1;
              ay <= ay - mer_pkg::PROD_W'(a2);
            end
          end
        end
      end
      ST_FIX: d <= d2_init;
      ST_R2: begin
        if (out_free) begin
          cnt <= cnt_inc;
          x   <= px;
          y   <= py;
          ay  <= ay - mer_pkg::PROD_W'(a2);
          if (d_neg) begin
            bx <= bx + mer_pkg::PROD_W'(b2);
            d  <= d + (bxe <<< 3) + (b2e <<< 3) + step_y2;
          end else begin
            d  <= d + step_y2;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register: hold until taken, load on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      pt.valid <= 1'b0;
    end else if (emit) begin
      pt.valid <= 1'b1;
    end else if (pt.ready) begin
      pt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pt.q1_x      <= cxe + pxe;
      pt.q1_y      <= cye + pye;
      pt.q2_x      <= cxe - pxe;
      pt.q2_y      <= cye + pye;
      pt.q3_x      <= cxe - pxe;
      pt.q3_y      <= cye - pye;
      pt.q4_x      <= cxe + pxe;
      pt.q4_y      <= cye - pye;
      pt.last_step <= last;
    end
  end

  a_fix_to_r2: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIX |=> state == ST_R2)
    else $error("region change bubble did not enter region 2");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    emit && last |=> state == ST_IDLE)
    else $error("walker kept running after the final point");

  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> cnt < mer_pkg::CNT_W'(MAX_STEPS))
    else $error("step count passed the limit");

  a_bx_track: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> bx == mer_pkg::PROD_W'(mer_pkg::PROD_W'(b2) * mer_pkg::PROD_W'(x)))
    else $error("b^2 x term out of step with x");

  a_ay_track: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> ay == mer_pkg::PROD_W'(mer_pkg::PROD_W'(a2) * mer_pkg::PROD_W'(y)))
    else $error("a^2 y term out of step with y");

endmodule
